@@ sv/bsc_pkg.sv @@
// shared constants, register codes and helpers for the barometric compensation pipeline
// no dependencies; used by bsc_div and baro_sensor_compensation_top
`default_nettype none

package bsc_pkg;

    // divider geometry: one quotient bit per stage
    localparam int DIV_W = 32;
    localparam int DIV_N = DIV_W;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OVERSAMPLING = 3'd0;
    localparam t_cfg_idx CFG_AC1_AC2      = 3'd1;
    localparam t_cfg_idx CFG_AC3_AC4      = 3'd2;
    localparam t_cfg_idx CFG_AC5_AC6      = 3'd3;
    localparam t_cfg_idx CFG_B1_B2        = 3'd4;
    localparam t_cfg_idx CFG_MC_MD        = 3'd5;

    // reset calibration (datasheet example)
    localparam logic [1:0]  RST_OSS     = 2'd3;
    localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
    localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
    localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
    localparam logic [31:0] RST_B1_B2   = 32'd405667844;
    localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

    // signed divide by 2**sh, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v,
                                                   input int unsigned sh);
        logic signed [31:0] bias;
        bias = v[31] ? signed'((32'd1 << sh) - 32'd1) : 32'sd0;
        return (v + bias) >>> sh;
    endfunction

endpackage

`default_nettype wire

@@ sv/baro_sensor_compensation_top.sv @@
// Barometric sensor compensation: takes one raw temperature word and one raw pressure
// reading per item and returns compensated temperature (0.1 degC) and pressure (Pa).
// One item enters every cycle unless the output stalls; each result passes through the
// two 33-register dividers (temperature and pressure) and the multiply stages around
// them. A stalled output holds the whole pipeline. A zero divisor raises divide_error
// and zeroes both results. The configuration port is always ready; the user must write
// it only while no item is in flight, as the block itself does not enforce this.
// depends on bsc_pkg and bsc_div
`default_nettype none

module baro_sensor_compensation_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [39:0]            s_axis_tdata,  // [15:0] raw_temperature, [39:16] raw_pressure
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [47:0]            m_axis_tdata,  // [15:0] temperature, [47:16] pressure
    output logic [0:0]             m_axis_tuser,  // [0] divide_error
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  bsc_pkg::t_cfg_idx      i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import bsc_pkg::*;

    localparam int NSTG = 3 + (DIV_N + 1) + 9 + (DIV_N + 1) + 5;

    localparam logic signed [31:0] K_B6_OFS  = 32'sd4000;
    localparam logic signed [31:0] K_C3038   = 32'sd3038;
    localparam logic signed [31:0] K_CM7357  = -32'sd7357;
    localparam logic signed [31:0] K_C3791   = 32'sd3791;
    localparam logic [15:0]        K_SCALE   = 16'd50000;
    localparam logic signed [31:0] K_C32768  = 32'sd32768;

    typedef struct packed {
        logic signed [31:0] x1;
        logic               neg;
        logic               err;
        logic [23:0]        up;
    } t_sb1;

    typedef struct packed {
        logic [15:0] temp;
        logic        err;
        logic        big;
    } t_sb2;

    // configuration registers
    logic [1:0]  r_oss;
    logic [31:0] r_c12, r_c34, r_c56, r_cb, r_cm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss <= RST_OSS;
            r_c12 <= RST_AC1_AC2;
            r_c34 <= RST_AC3_AC4;
            r_c56 <= RST_AC5_AC6;
            r_cb  <= RST_B1_B2;
            r_cm  <= RST_MC_MD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OVERSAMPLING: r_oss <= i_cfg_data[1:0];
                CFG_AC1_AC2:      r_c12 <= i_cfg_data;
                CFG_AC3_AC4:      r_c34 <= i_cfg_data;
                CFG_AC5_AC6:      r_c56 <= i_cfg_data;
                CFG_B1_B2:        r_cb  <= i_cfg_data;
                CFG_MC_MD:        r_cm  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // calibration words, sign-extended to 32 bits where signed; mc stays a signed 16-bit word
    logic signed [31:0] ac1, ac2, ac3, b1, b2, md;
    logic signed [15:0] mc;
    logic [15:0]        ac4, ac5, ac6;
    assign ac1 = 32'(signed'(r_c12[31:16]));
    assign ac2 = 32'(signed'(r_c12[15:0]));
    assign ac3 = 32'(signed'(r_c34[31:16]));
    assign ac4 = r_c34[15:0];
    assign ac5 = r_c56[31:16];
    assign ac6 = r_c56[15:0];
    assign b1  = 32'(signed'(r_cb[31:16]));
    assign b2  = 32'(signed'(r_cb[15:0]));
    assign mc  = signed'(r_cm[31:16]);
    assign md  = 32'(signed'(r_cm[15:0]));

    // pipeline advance: stalls only when a finished result is not taken
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [NSTG-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // s1: offset raw temperature, align raw pressure
    logic signed [16:0] r_s1_a, n_s1_a;
    logic [23:0]        r_s1_up, n_s1_up;
    assign n_s1_a  = $signed({1'b0, s_axis_tdata[15:0]}) - $signed({1'b0, ac6});
    assign n_s1_up = s_axis_tdata[39:16] >> (4'd8 - {2'b00, r_oss});

    // s2: times ac5
    logic signed [33:0] w_s2_prod;
    logic signed [31:0] r_s2_p;
    logic [23:0]        r_s2_up;
    assign w_s2_prod = r_s1_a * $signed({1'b0, ac5});

    // s3: x1 and the temperature divisor
    logic signed [31:0] r_s3_x1, r_s3_den, n_s3_x1;
    logic [23:0]        r_s3_up;
    assign n_s3_x1 = sdiv_p2(r_s2_p, 15);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a   <= n_s1_a;
            r_s1_up  <= n_s1_up;
            r_s2_p   <= w_s2_prod[31:0];
            r_s2_up  <= r_s1_up;
            r_s3_x1  <= n_s3_x1;
            r_s3_den <= n_s3_x1 + md;
            r_s3_up  <= r_s2_up;
        end
    end

    // divider one: |mc * 2048| / |x1 + md|
    logic [15:0] w_mc_abs;
    logic [31:0] w_d1_num, w_d1_den, w_d1_quo;
    assign w_mc_abs = mc[15] ? 16'(-mc) : 16'(mc);
    assign w_d1_num = {5'b0, w_mc_abs, 11'b0};
    assign w_d1_den = r_s3_den[31] ? 32'(-r_s3_den) : 32'(r_s3_den);

    bsc_div u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_d1_num),
        .i_den (w_d1_den),
        .o_quo (w_d1_quo)
    );

    t_sb1 r_sb1 [0:DIV_N];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1[0].x1  <= r_s3_x1;
            r_sb1[0].neg <= mc[15] ^ r_s3_den[31];
            r_sb1[0].err <= (r_s3_den == 32'sd0);
            r_sb1[0].up  <= r_s3_up;
            for (int k = 1; k <= DIV_N; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    // t1: b5, temperature, b6
    logic signed [31:0] w_t1_x2, w_t1_b5, w_t1_t8;
    assign w_t1_x2 = r_sb1[DIV_N].neg ? -signed'(w_d1_quo) : signed'(w_d1_quo);
    assign w_t1_b5 = r_sb1[DIV_N].x1 + w_t1_x2;
    assign w_t1_t8 = w_t1_b5 + 32'sd8;

    logic [15:0]        r_t1_temp;
    logic signed [31:0] r_t1_b6;
    logic               r_t1_err;
    logic [23:0]        r_t1_up;

    // t2: products of b6
    logic signed [63:0] w_t2_sq, w_t2_m2, w_t2_m3;
    assign w_t2_sq = r_t1_b6 * r_t1_b6;
    assign w_t2_m2 = ac2 * r_t1_b6;
    assign w_t2_m3 = ac3 * r_t1_b6;
    logic signed [31:0] r_t2_sq, r_t2_m2, r_t2_m3;

    // t3: scale down
    logic signed [31:0] r_t3_sq, r_t3_x2a, r_t3_x1b;

    // t4: products of sq
    logic signed [63:0] w_t4_pb2, w_t4_pb1;
    assign w_t4_pb2 = b2 * r_t3_sq;
    assign w_t4_pb1 = b1 * r_t3_sq;
    logic signed [31:0] r_t4_pb2, r_t4_pb1, r_t4_x2a, r_t4_x1b;

    // t5: scale down
    logic signed [31:0] r_t5_x1a, r_t5_x2b, r_t5_x2a, r_t5_x1b;

    // t6: sums for b3 and b4
    logic signed [31:0] r_t6_s, r_t6_y;

    // t7: b3 and the b4 multiplicand
    logic signed [31:0] w_t7_sh;
    assign w_t7_sh = (r_t6_s << r_oss) + 32'sd2;
    logic signed [31:0] r_t7_b3, r_t7_u;

    // t8: b4 and up - b3
    logic [47:0] w_t8_b4p;
    assign w_t8_b4p = ac4 * unsigned'(r_t7_u);
    logic [31:0] r_t8_b4, r_t8_diff;

    // t9: b7
    logic [47:0] w_t9_b7p;
    assign w_t9_b7p = r_t8_diff * (K_SCALE >> r_oss);
    logic [31:0] r_t9_b7, r_t9_b4;

    // per-stage carry of temperature, error flag and raw pressure
    logic [15:0] r_t_temp [2:9];
    logic        r_t_err  [2:9];
    logic [23:0] r_t_up   [2:7];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_temp <= 16'(sdiv_p2(w_t1_t8, 4));
            r_t1_b6   <= w_t1_b5 - K_B6_OFS;
            r_t1_err  <= r_sb1[DIV_N].err;
            r_t1_up   <= r_sb1[DIV_N].up;

            r_t2_sq <= w_t2_sq[31:0];
            r_t2_m2 <= w_t2_m2[31:0];
            r_t2_m3 <= w_t2_m3[31:0];

            r_t3_sq  <= sdiv_p2(r_t2_sq, 12);
            r_t3_x2a <= sdiv_p2(r_t2_m2, 11);
            r_t3_x1b <= sdiv_p2(r_t2_m3, 13);

            r_t4_pb2 <= w_t4_pb2[31:0];
            r_t4_pb1 <= w_t4_pb1[31:0];
            r_t4_x2a <= r_t3_x2a;
            r_t4_x1b <= r_t3_x1b;

            r_t5_x1a <= sdiv_p2(r_t4_pb2, 11);
            r_t5_x2b <= sdiv_p2(r_t4_pb1, 16);
            r_t5_x2a <= r_t4_x2a;
            r_t5_x1b <= r_t4_x1b;

            r_t6_s <= (ac1 <<< 2) + r_t5_x1a + r_t5_x2a;
            r_t6_y <= r_t5_x1b + r_t5_x2b + 32'sd2;

            r_t7_b3 <= sdiv_p2(w_t7_sh, 2);
            r_t7_u  <= sdiv_p2(r_t6_y, 2) + K_C32768;

            r_t8_b4   <= w_t8_b4p[31:0] >> 15;
            r_t8_diff <= {8'b0, r_t_up[7]} - unsigned'(r_t7_b3);

            r_t9_b7 <= w_t9_b7p[31:0];
            r_t9_b4 <= r_t8_b4;

            r_t_temp[2] <= r_t1_temp;
            r_t_err[2]  <= r_t1_err;
            r_t_up[2]   <= r_t1_up;
            for (int k = 3; k <= 9; k++) begin
                r_t_temp[k] <= r_t_temp[k-1];
                r_t_err[k]  <= r_t_err[k-1];
            end
            for (int k = 3; k <= 7; k++) begin
                r_t_up[k] <= r_t_up[k-1];
            end
        end
    end

    // divider two: b7 (doubled when it fits) / b4
    logic        w_d2_big;
    logic [31:0] w_d2_num, w_d2_quo;
    assign w_d2_big = r_t9_b7[31];
    assign w_d2_num = w_d2_big ? r_t9_b7 : {r_t9_b7[30:0], 1'b0};

    bsc_div u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_d2_num),
        .i_den (r_t9_b4),
        .o_quo (w_d2_quo)
    );

    t_sb2 r_sb2 [0:DIV_N];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb2[0].temp <= r_t_temp[9];
            r_sb2[0].err  <= r_t_err[9] || (r_t9_b4 == 32'd0);
            r_sb2[0].big  <= w_d2_big;
            for (int k = 1; k <= DIV_N; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    // f1: raw pressure estimate
    logic signed [31:0] w_f1_p;
    assign w_f1_p = r_sb2[DIV_N].big ? signed'({w_d2_quo[30:0], 1'b0}) : signed'(w_d2_quo);
    logic signed [31:0] r_f1_p, r_f1_pd;

    // f2: square and linear term
    logic signed [63:0] w_f2_sq, w_f2_m7;
    assign w_f2_sq = r_f1_pd * r_f1_pd;
    assign w_f2_m7 = K_CM7357 * r_f1_p;
    logic signed [31:0] r_f2_sq, r_f2_m7, r_f2_p;

    // f3: quadratic coefficient
    logic signed [63:0] w_f3_pr;
    assign w_f3_pr = r_f2_sq * K_C3038;
    logic signed [31:0] r_f3_pr, r_f3_x2, r_f3_p;

    // f4: correction sum
    logic signed [31:0] r_f4_s, r_f4_p;

    // f5: output register, zeroed on a divide error
    logic signed [31:0] w_f5_p;
    assign w_f5_p = r_f4_p + sdiv_p2(r_f4_s, 4);
    logic [15:0] r_o_temp;
    logic [31:0] r_o_p;
    logic        r_o_err;

    logic [15:0] r_f_temp [1:4];
    logic        r_f_err  [1:4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_p  <= w_f1_p;
            r_f1_pd <= sdiv_p2(w_f1_p, 8);

            r_f2_sq <= w_f2_sq[31:0];
            r_f2_m7 <= w_f2_m7[31:0];
            r_f2_p  <= r_f1_p;

            r_f3_pr <= w_f3_pr[31:0];
            r_f3_x2 <= sdiv_p2(r_f2_m7, 16);
            r_f3_p  <= r_f2_p;

            r_f4_s <= sdiv_p2(r_f3_pr, 16) + r_f3_x2 + K_C3791;
            r_f4_p <= r_f3_p;

            r_o_err  <= r_f_err[4];
            r_o_temp <= r_f_err[4] ? 16'd0 : r_f_temp[4];
            r_o_p    <= r_f_err[4] ? 32'd0 : unsigned'(w_f5_p);

            r_f_temp[1] <= r_sb2[DIV_N].temp;
            r_f_err[1]  <= r_sb2[DIV_N].err;
            for (int k = 2; k <= 4; k++) begin
                r_f_temp[k] <= r_f_temp[k-1];
                r_f_err[k]  <= r_f_err[k-1];
            end
        end
    end

    assign m_axis_tvalid   = r_vld[NSTG-1];
    assign m_axis_tdata    = {r_o_p, r_o_temp};
    assign m_axis_tuser[0] = r_o_err;

`ifndef SYNTHESIS
    // pipeline empties on reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item lost at entry");
    // a stall freezes every stage's valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    // a divide error zeroes the results
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero result with divide error");
`endif

endmodule

`default_nettype wire

@@ sv/bsc_div.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on bsc_pkg for the word width and stage count
`default_nettype none

module bsc_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bsc_pkg::DIV_W-1:0]  i_num,
    input  logic [bsc_pkg::DIV_W-1:0]  i_den,
    output logic [bsc_pkg::DIV_W-1:0]  o_quo
);
    import bsc_pkg::*;

    logic [DIV_W-1:0] r_rem [0:DIV_N];
    logic [DIV_W-1:0] r_num [0:DIV_N];
    logic [DIV_W-1:0] r_den [0:DIV_N];
    logic [DIV_W-1:0] r_quo [0:DIV_N];

    // load stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one trial subtraction per stage
    for (genvar k = 0; k < DIV_N; k++) begin : g_stage
        logic [DIV_W:0] w_try;
        logic [DIV_W:0] w_diff;
        logic           w_bit;
        assign w_try  = {r_rem[k], r_num[k][DIV_W-1]};
        assign w_diff = w_try - {1'b0, r_den[k]};
        assign w_bit  = ~w_diff[DIV_W];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_bit ? w_diff[DIV_W-1:0] : w_try[DIV_W-1:0];
                r_num[k+1] <= {r_num[k][DIV_W-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][DIV_W-2:0], w_bit};
            end
        end
    end

    assign o_quo = r_quo[DIV_N];

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for baro_sensor_compensation_top: directed table, then random phases
// predicts readings without a table expectation with its own compensation model; depends on bsc_pkg and the rtl
`default_nettype none

module tb_top;
    import bsc_pkg::*;

    localparam int LATENCY_WAIT = 120;
    localparam int RANDOM_ITEMS = 170;

    typedef struct {
        logic [15:0] temperature;
        logic [31:0] pressure;
        logic        divide_error;
    } t_reading;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [31:0] data;
        logic [15:0] ut;
        logic [23:0] up;
        bit          known;
        t_reading    want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [15:0] raw_temperature, [39:16] raw_pressure
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [15:0] temperature, [47:16] pressure
    logic [0:0]  m_axis_tuser;        // [0] divide_error
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_OVERSAMPLING;
    logic [31:0] i_cfg_data = '0;

    // mirror of the calibration registers
    logic [1:0]  cal_oss = RST_OSS;
    logic [31:0] cal_ac1_ac2 = RST_AC1_AC2;
    logic [31:0] cal_ac3_ac4 = RST_AC3_AC4;
    logic [31:0] cal_ac5_ac6 = RST_AC5_AC6;
    logic [31:0] cal_b1_b2 = RST_B1_B2;
    logic [31:0] cal_mc_md = RST_MC_MD;

    t_reading pending_readings[$];
    int       mismatches = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    t_step    directed[$];

    baro_sensor_compensation_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // datasheet compensation with 32-bit wrap and truncating division
    function automatic t_reading compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
        int          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        int          x1, x2, x3, b5, b6, b3, sq, tmp, temp, p, den;
        int unsigned ac4, up, b4, b7, q, x3_u, scale;
        longint      wide;
        t_reading    r;
        ac1 = $signed(cal_ac1_ac2[31:16]);
        ac2 = $signed(cal_ac1_ac2[15:0]);
        ac3 = $signed(cal_ac3_ac4[31:16]);
        ac4 = cal_ac3_ac4[15:0];
        ac5 = cal_ac5_ac6[31:16];
        ac6 = cal_ac5_ac6[15:0];
        b1  = $signed(cal_b1_b2[31:16]);
        b2  = $signed(cal_b1_b2[15:0]);
        mc  = $signed(cal_mc_md[31:16]);
        md  = $signed(cal_mc_md[15:0]);
        ut  = ut_raw;
        up  = up_raw;
        up  = up >> (8 - cal_oss);
        r   = '{16'd0, 32'd0, 1'b1};
        // temperature
        x1  = ((ut - ac6) * ac5) / 32768;
        den = x1 + md;
        if (den == 0) return r;
        wide = longint'(mc) * 2048 / longint'(den);
        x2   = int'(wide);
        b5   = x1 + x2;
        temp = (b5 + 8) / 16;
        // pressure
        b6  = b5 - 4000;
        sq  = (b6 * b6) / 4096;
        x1  = (b2 * sq) / 2048;
        x2  = (ac2 * b6) / 2048;
        x3  = x1 + x2;
        tmp = (ac1 * 4 + x3) << cal_oss;
        b3  = (tmp + 2) / 4;
        x1  = (ac3 * b6) / 8192;
        x2  = (b1 * sq) / 65536;
        x3  = (x1 + x2 + 2) / 4;
        x3_u  = x3 + 32768;
        b4    = (ac4 * x3_u) >> 15;
        scale = 32'd50000 >> cal_oss;
        b7    = (up - int'(b3)) * scale;
        if (b4 == 0) return r;
        if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
        else q = (b7 / b4) * 32'd2;
        p  = q;
        x1 = (p / 256) * (p / 256);
        x1 = (x1 * 3038) / 65536;
        x2 = (-7357 * p) / 65536;
        p  = p + (x1 + x2 + 3791) / 16;
        r.temperature  = temp[15:0];
        r.pressure     = p;
        r.divide_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // one register write; valid stays high until the caller lowers it
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OVERSAMPLING: cal_oss = data[1:0];
            CFG_AC1_AC2:      cal_ac1_ac2 = data;
            CFG_AC3_AC4:      cal_ac3_ac4 = data;
            CFG_AC5_AC6:      cal_ac5_ac6 = data;
            CFG_B1_B2:        cal_b1_b2 = data;
            CFG_MC_MD:        cal_mc_md = data;
            default: ;
        endcase
    endtask

    // one reading, with random idle cycles ahead of it
    task automatic send_reading(logic [15:0] ut, logic [23:0] up, bit known, t_reading want);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {up, ut};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_readings.push_back(known ? want : compensate(ut, up));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coef(logic [31:0] nominal);
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return $urandom;
            default: return nominal ^ ($urandom & 32'h00ff_00ff);
        endcase
    endfunction

    // result checker and random output stalls
    always @(posedge i_clk) begin
        t_reading w;
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata[31:0], 32'd0);
            end else begin
                w = pending_readings.pop_front();
                if (m_axis_tdata[15:0] !== w.temperature)
                    report_mismatch("temperature", m_axis_tdata[15:0], w.temperature);
                if (m_axis_tdata[47:16] !== w.pressure)
                    report_mismatch("pressure", m_axis_tdata[47:16], w.pressure);
                if (m_axis_tuser[0] !== w.divide_error)
                    report_mismatch("divide_error", m_axis_tuser[0], w.divide_error);
            end
        end
    end

    // stimulus
    initial begin
        t_reading none, sheet, fault;
        bit       cfg_open;
        logic [15:0] ut;
        none  = '{16'd0, 32'd0, 1'b0};
        sheet = '{16'd150, 32'd69965, 1'b0};
        fault = '{16'd0, 32'd0, 1'b1};
        // directed steps; reset calibration is the datasheet example
        directed = '{
            '{0, CFG_OVERSAMPLING, 0, 16'h0000, 24'h000000, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'hffff, 24'hffffff, 0, none},
            '{1, CFG_OVERSAMPLING, 0, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 8, 1, sheet},
            '{0, CFG_OVERSAMPLING, 0, 16'h0000, 24'h000000, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'hffff, 24'hffffff, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'h5555, 24'haaaaaa, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'haaaa, 24'h555555, 0, none},
            // zero temperature divisor: md of zero and ut equal to ac6
            '{1, CFG_MC_MD, 32'hddf9_0000, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd23153, 24'h123456, 1, fault},
            '{1, CFG_MC_MD, RST_MC_MD, 0, 0, 0, none},
            // zero pressure divisor: ac4 of zero
            '{1, CFG_AC3_AC4, 32'hc7d1_0000, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 8, 1, fault},
            '{1, CFG_AC3_AC4, RST_AC3_AC4, 0, 0, 0, none},
            // unused indexes must not disturb the calibration
            '{1, t_cfg_idx'(6), 32'hffff_ffff, 0, 0, 0, none},
            '{1, t_cfg_idx'(7), 32'h0000_0000, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 8, 1, sheet},
            '{1, CFG_OVERSAMPLING, 1, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 7, 0, none},
            '{1, CFG_OVERSAMPLING, 2, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 6, 0, none},
            '{1, CFG_OVERSAMPLING, 3, 0, 0, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'd27898, 24'd23843 << 5, 0, none},
            '{0, CFG_OVERSAMPLING, 0, 16'h8000, 24'h800000, 0, none}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cfg_open = 0;
        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                if (!cfg_open) drain();
                write_reg(directed[k].idx, directed[k].data);
                cfg_open = 1;
            end else begin
                if (cfg_open) i_cfg_valid <= 1'b0;
                cfg_open = 0;
                send_reading(directed[k].ut, directed[k].up, directed[k].known, directed[k].want);
            end
        end
        drain();

        // random phases: free flow, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 73) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 73) : 0;
            write_reg(CFG_OVERSAMPLING, (ph == 0) ? 32'd0 : (ph == 3) ? 32'd3 : $urandom);
            write_reg(CFG_AC1_AC2, pick_coef(RST_AC1_AC2));
            write_reg(CFG_AC3_AC4, pick_coef(RST_AC3_AC4));
            write_reg(CFG_AC5_AC6, pick_coef(RST_AC5_AC6));
            write_reg(CFG_B1_B2, pick_coef(RST_B1_B2));
            write_reg(CFG_MC_MD, pick_coef(RST_MC_MD));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // mostly plausible temperature words, some anywhere in range; pressure words anywhere in range
                ut = ($urandom_range(3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(34000, 20000));
                send_reading(ut, 24'($urandom), 0, none);
            end
            drain();
        end

        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
